[design/lpg_pkg.sv]
// Shared types and constants for the line pixel generator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lpg_pkg;

	// Coordinate width and the widths derived from it.
	localparam int COORD_BITS = 11;
	localparam int ERR_BITS   = COORD_BITS + 2;
	localparam int STEP_BITS  = COORD_BITS + 1;
	localparam int COLOR_BITS = 16;

	// Command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Step direction codes.
	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_PLUS  = 2'd1;
	localparam logic [1:0] DIR_MINUS = 2'd3;

	// Command beat as it arrives at the block.
	typedef struct packed {
		logic                  cmd;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
		logic [COLOR_BITS-1:0] line_color;
	} cmd_item_t;

	// Pixel beat as it leaves the block.
	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  pixel_valid;
		logic                  last_pixel;
	} pix_item_t;

	// Classified command as held in the queue between front and back.
	typedef struct packed {
		logic                  cmd;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [1:0]            dir_col;
		logic [1:0]            dir_row;
		logic [COORD_BITS-1:0] abs_dx;
		logic [COORD_BITS-1:0] abs_dy;
		logic [COORD_BITS-1:0] major_len;
		logic [COLOR_BITS-1:0] line_color;
	} cls_item_t;

endpackage

`default_nettype wire

[design/lpg_front.sv]
// Front part: classifies each command beat and works out the line setup.
// Depends on lpg_pkg.
`default_nettype none

module lpg_front (
	input  wire lpg_pkg::cmd_item_t cmd_item,
	input  wire                     cmd_valid,
	output logic                    cmd_stall,
	output lpg_pkg::cls_item_t      cls_item,
	output logic                    cls_valid,
	input  wire                     cls_stall
);

	// Handshake passes straight to the queue; the queue holds the state.
	assign cls_valid = cmd_valid;
	assign cmd_stall = cls_stall;

	// Directions, absolute deltas and the major-axis distance.
	always_comb begin
		cls_item.cmd        = cmd_item.cmd;
		cls_item.x_start    = cmd_item.x_start;
		cls_item.y_start    = cmd_item.y_start;
		cls_item.line_color = cmd_item.line_color;
		if (cmd_item.x_end > cmd_item.x_start) begin
			cls_item.dir_col = lpg_pkg::DIR_PLUS;
			cls_item.abs_dx  = cmd_item.x_end - cmd_item.x_start;
		end else if (cmd_item.x_end == cmd_item.x_start) begin
			cls_item.dir_col = lpg_pkg::DIR_NONE;
			cls_item.abs_dx  = '0;
		end else begin
			cls_item.dir_col = lpg_pkg::DIR_MINUS;
			cls_item.abs_dx  = cmd_item.x_start - cmd_item.x_end;
		end
		if (cmd_item.y_end > cmd_item.y_start) begin
			cls_item.dir_row = lpg_pkg::DIR_PLUS;
			cls_item.abs_dy  = cmd_item.y_end - cmd_item.y_start;
		end else if (cmd_item.y_end == cmd_item.y_start) begin
			cls_item.dir_row = lpg_pkg::DIR_NONE;
			cls_item.abs_dy  = '0;
		end else begin
			cls_item.dir_row = lpg_pkg::DIR_MINUS;
			cls_item.abs_dy  = cmd_item.y_start - cmd_item.y_end;
		end
		cls_item.major_len = (cls_item.abs_dx > cls_item.abs_dy) ?
			cls_item.abs_dx : cls_item.abs_dy;
	end

endmodule

`default_nettype wire

[design/lpg_queue.sv]
// Two-entry queue of classified commands between the front and back parts.
// Depends on lpg_pkg.
`default_nettype none

module lpg_queue (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire lpg_pkg::cls_item_t wr_item,
	input  wire                     wr_valid,
	output logic                    wr_stall,
	output lpg_pkg::cls_item_t      rd_item,
	output logic                    rd_valid,
	input  wire                     rd_stall
);

	lpg_pkg::cls_item_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               push;
	logic               pop;

	// Handshake on both sides of the queue.
	assign wr_stall = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;
	assign rd_item  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// The fill count never passes the depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue fill count beyond depth");

	// A lone write grows the count by one.
	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("queue count did not follow a write");

endmodule

`default_nettype wire

[design/lpg_back.sv]
// Back part: holds the line state, steps the error accumulators and
// drives the registered pixel output. Depends on lpg_pkg.
`default_nettype none

module lpg_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire lpg_pkg::cls_item_t cls_item,
	input  wire                     cls_valid,
	output logic                    cls_stall,
	output lpg_pkg::pix_item_t      pix_item,
	output logic                    pix_valid,
	input  wire                     pix_stall
);

	localparam int CB = lpg_pkg::COORD_BITS;
	localparam int EB = lpg_pkg::ERR_BITS;
	localparam int SB = lpg_pkg::STEP_BITS;

	// Line state.
	logic [CB-1:0]              cur_col_q, cur_row_q;
	logic [EB-1:0]              err_col_q, err_row_q;
	logic [CB-1:0]              abs_dx_q, abs_dy_q;
	logic [1:0]                 dir_col_q, dir_row_q;
	logic [CB-1:0]              major_len_q;
	logic [SB-1:0]              steps_left_q;
	logic [lpg_pkg::COLOR_BITS-1:0] held_color_q;
	logic                       active_q;

	// Next-state values.
	logic [CB-1:0]              cur_col_d, cur_row_d;
	logic [EB-1:0]              err_col_d, err_row_d;
	logic [CB-1:0]              abs_dx_d, abs_dy_d;
	logic [1:0]                 dir_col_d, dir_row_d;
	logic [CB-1:0]              major_len_d;
	logic [SB-1:0]              steps_left_d;
	logic [lpg_pkg::COLOR_BITS-1:0] held_color_d;
	logic                       active_d;
	logic [EB-1:0]              sum_col, sum_row;
	lpg_pkg::pix_item_t         pix_d;

	lpg_pkg::pix_item_t         pix_q;
	logic                       pix_valid_q;
	logic                       pop;

	// One coordinate step in the given direction, wrapping like an adder.
	function automatic logic [CB-1:0] move(input logic [CB-1:0] pos,
		input logic [1:0] dir);
		logic [CB-1:0] res;
		unique case (dir)
			lpg_pkg::DIR_PLUS:  res = pos + {{(CB-1){1'b0}}, 1'b1};
			lpg_pkg::DIR_MINUS: res = pos - {{(CB-1){1'b0}}, 1'b1};
			default:            res = pos;
		endcase
		return res;
	endfunction

	// Take a queued command whenever the output register is free or draining.
	assign pop       = cls_valid && (!pix_valid_q || !pix_stall);
	assign cls_stall = !(!pix_valid_q || !pix_stall);
	assign pix_item  = pix_q;
	assign pix_valid = pix_valid_q;

	// Error accumulation for a step from the current line state.
	assign sum_col = err_col_q + {2'b00, abs_dx_q};
	assign sum_row = err_row_q + {2'b00, abs_dy_q};

	// Command execution: load, step, or step with no line in progress.
	always_comb begin
		cur_col_d    = cur_col_q;
		cur_row_d    = cur_row_q;
		err_col_d    = err_col_q;
		err_row_d    = err_row_q;
		abs_dx_d     = abs_dx_q;
		abs_dy_d     = abs_dy_q;
		dir_col_d    = dir_col_q;
		dir_row_d    = dir_row_q;
		major_len_d  = major_len_q;
		steps_left_d = steps_left_q;
		held_color_d = held_color_q;
		active_d     = active_q;
		pix_d        = '0;
		if (cls_item.cmd == lpg_pkg::CMD_LOAD) begin
			// First advance from a zero error never moves the point.
			cur_col_d    = cls_item.x_start;
			cur_row_d    = cls_item.y_start;
			err_col_d    = {2'b00, cls_item.abs_dx};
			err_row_d    = {2'b00, cls_item.abs_dy};
			abs_dx_d     = cls_item.abs_dx;
			abs_dy_d     = cls_item.abs_dy;
			dir_col_d    = cls_item.dir_col;
			dir_row_d    = cls_item.dir_row;
			major_len_d  = cls_item.major_len;
			steps_left_d = {1'b0, cls_item.major_len} + {{(SB-1){1'b0}}, 1'b1};
			held_color_d = cls_item.line_color;
			active_d     = 1'b1;
			pix_d.pixel_x     = cls_item.x_start;
			pix_d.pixel_y     = cls_item.y_start;
			pix_d.pixel_color = cls_item.line_color;
			pix_d.pixel_valid = 1'b1;
			pix_d.last_pixel  = 1'b0;
		end else if (active_q) begin
			pix_d.pixel_x     = cur_col_q;
			pix_d.pixel_y     = cur_row_q;
			pix_d.pixel_color = held_color_q;
			pix_d.pixel_valid = 1'b1;
			pix_d.last_pixel  = (steps_left_q <= {{(SB-1){1'b0}}, 1'b1});
			if (pix_d.last_pixel) begin
				steps_left_d = '0;
				active_d     = 1'b0;
			end else begin
				steps_left_d = steps_left_q - {{(SB-1){1'b0}}, 1'b1};
			end
			err_col_d = sum_col;
			err_row_d = sum_row;
			if (sum_col > {2'b00, major_len_q}) begin
				err_col_d = sum_col - {2'b00, major_len_q};
				cur_col_d = move(cur_col_q, dir_col_q);
			end
			if (sum_row > {2'b00, major_len_q}) begin
				err_row_d = sum_row - {2'b00, major_len_q};
				cur_row_d = move(cur_row_q, dir_row_q);
			end
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			err_col_q    <= '0;
			err_row_q    <= '0;
			abs_dx_q     <= '0;
			abs_dy_q     <= '0;
			dir_col_q    <= lpg_pkg::DIR_NONE;
			dir_row_q    <= lpg_pkg::DIR_NONE;
			major_len_q  <= '0;
			steps_left_q <= '0;
			held_color_q <= '0;
			active_q     <= 1'b0;
		end else if (pop) begin
			cur_col_q    <= cur_col_d;
			cur_row_q    <= cur_row_d;
			err_col_q    <= err_col_d;
			err_row_q    <= err_row_d;
			abs_dx_q     <= abs_dx_d;
			abs_dy_q     <= abs_dy_d;
			dir_col_q    <= dir_col_d;
			dir_row_q    <= dir_row_d;
			major_len_q  <= major_len_d;
			steps_left_q <= steps_left_d;
			held_color_q <= held_color_d;
			active_q     <= active_d;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (pop) begin
			pix_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			pix_q <= pix_d;
		end
	end

	// A line in progress always has pixels left to give.
	a_active_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (steps_left_q != '0))
		else $error("active line with no steps left");

	// The error accumulators stay within the major distance during a line.
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (err_col_q <= {2'b00, major_len_q} &&
			err_row_q <= {2'b00, major_len_q}))
		else $error("error accumulator beyond major distance");

	// The last-pixel mark only comes with a real pixel.
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid_q && pix_q.last_pixel) |-> pix_q.pixel_valid)
		else $error("last pixel marked on an idle result");

endmodule

`default_nettype wire

[design/line_pixel_generator_core.sv]
// Top level of the line pixel generator: front classifier, queue, back stepper.
// Depends on lpg_pkg, lpg_front, lpg_queue and lpg_back.
//
// Each command beat gives exactly one pixel beat. A load command sets up a
// Bresenham line and returns its start pixel; each step command returns the
// next pixel, with last_pixel on the final one (a line gives distance + 2
// pixels and the start pixel appears twice). A step with no line in progress
// returns an all-zero beat with pixel_valid low. The block sustains one
// command per cycle while the pixel side does not stall: the front classifies a
// command and writes it to a two-entry queue in the cycle it is accepted, and the
// back executes one queued command per cycle into the output register, so a pixel
// is registered in a queue entry and then in the output register. The combinational
// error add, compare and subtract in the back part sets that rate.
`default_nettype none

module line_pixel_generator_core (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire lpg_pkg::cmd_item_t cmd_item,
	input  wire                     cmd_valid,
	output logic                    cmd_stall,
	output lpg_pkg::pix_item_t      pix_item,
	output logic                    pix_valid,
	input  wire                     pix_stall
);

	lpg_pkg::cls_item_t front_item;
	logic               front_valid;
	logic               front_stall;
	lpg_pkg::cls_item_t queue_item;
	logic               queue_valid;
	logic               queue_stall;

	lpg_front u_front (
		.cmd_item  (cmd_item),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cls_item  (front_item),
		.cls_valid (front_valid),
		.cls_stall (front_stall)
	);

	lpg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (front_item),
		.wr_valid (front_valid),
		.wr_stall (front_stall),
		.rd_item  (queue_item),
		.rd_valid (queue_valid),
		.rd_stall (queue_stall)
	);

	lpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_item  (queue_item),
		.cls_valid (queue_valid),
		.cls_stall (queue_stall),
		.pix_item  (pix_item),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall)
	);

endmodule

`default_nettype wire

[dv/line_pixel_generator_core_tb.sv]
// Self-checking testbench for line_pixel_generator_core.
// Command beats go in; each pixel beat is checked in order against a Bresenham stepper
// kept in this file. Depends on lpg_pkg and the line_pixel_generator_core RTL.

module line_pixel_generator_core_tb;

	typedef logic [lpg_pkg::COORD_BITS-1:0] coord_t;
	typedef logic [lpg_pkg::COLOR_BITS-1:0] hue_t;

	// One row of the directed table: the beat, and the pixel beat when it is known by eye.
	typedef struct {
		lpg_pkg::cmd_item_t beat;
		bit                 typed;
		lpg_pkg::pix_item_t want;
	} plan_row_t;

	localparam int                 RANDOM_BEATS = 710;
	localparam int                 HOLD_CYCLES  = 300;
	localparam int                 CYCLE_LIMIT  = 500000;
	localparam int                 COORD_MAX    = (1 << lpg_pkg::COORD_BITS) - 1;
	localparam lpg_pkg::pix_item_t NO_PIXEL     = '0;

	logic               clk;
	logic               arst_n;
	lpg_pkg::cmd_item_t cmd_item;
	logic               cmd_valid;
	logic               cmd_stall;
	lpg_pkg::pix_item_t pix_item;
	logic               pix_valid;
	logic               pix_stall;

	lpg_pkg::pix_item_t want_pixels [$];
	plan_row_t          plan [$];
	int                 mismatches = 0;
	int                 beats_sent = 0;
	int                 cycles     = 0;
	bit                 tx_burst   = 1'b0;

	// Predicted line state.
	coord_t                         pen_col, pen_row;
	logic [lpg_pkg::ERR_BITS-1:0]   slack_col, slack_row;
	coord_t                         run_col, run_row;
	logic [1:0]                     heading_col, heading_row;
	coord_t                         major_run;
	logic [lpg_pkg::STEP_BITS-1:0]  pixels_owed;
	hue_t                           line_hue;
	logic                           drawing;

	line_pixel_generator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_item  (cmd_item),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.pix_item  (pix_item),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Beat builders for the table and the random part.
	function automatic lpg_pkg::cmd_item_t load_cmd(input coord_t xs, ys, xe, ye,
			input hue_t hue);
		lpg_pkg::cmd_item_t c;
		c.cmd        = lpg_pkg::CMD_LOAD;
		c.x_start    = xs;
		c.y_start    = ys;
		c.x_end      = xe;
		c.y_end      = ye;
		c.line_color = hue;
		return c;
	endfunction

	function automatic lpg_pkg::cmd_item_t step_cmd(input coord_t fill, input hue_t hue);
		lpg_pkg::cmd_item_t c;
		c = load_cmd(fill, fill, fill, fill, hue);
		c.cmd = lpg_pkg::CMD_STEP;
		return c;
	endfunction

	function automatic lpg_pkg::cmd_item_t noise_step();
		lpg_pkg::cmd_item_t c;
		c = load_cmd(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), hue_t'($urandom));
		c.cmd = lpg_pkg::CMD_STEP;
		return c;
	endfunction

	function automatic lpg_pkg::pix_item_t lit_pixel(input coord_t x, y, input hue_t hue,
			input logic last);
		lpg_pkg::pix_item_t p;
		p.pixel_x     = x;
		p.pixel_y     = y;
		p.pixel_color = hue;
		p.pixel_valid = 1'b1;
		p.last_pixel  = last;
		return p;
	endfunction

	// Direction and absolute distance along one axis.
	function automatic void axis_setup(input coord_t from, to, output logic [1:0] dir,
			output coord_t span);
		if (to > from) begin
			dir  = lpg_pkg::DIR_PLUS;
			span = to - from;
		end else if (to == from) begin
			dir  = lpg_pkg::DIR_NONE;
			span = '0;
		end else begin
			dir  = lpg_pkg::DIR_MINUS;
			span = from - to;
		end
	endfunction

	function automatic coord_t nudge(input coord_t pos, input logic [1:0] dir);
		case (dir)
			lpg_pkg::DIR_PLUS:  return pos + 1'b1;
			lpg_pkg::DIR_MINUS: return pos - 1'b1;
			default:            return pos;
		endcase
	endfunction

	// Error accumulation after every emitted pixel; a coordinate moves when its error
	// passes the major distance.
	function automatic void bresenham_step();
		slack_col = slack_col + {2'b00, run_col};
		slack_row = slack_row + {2'b00, run_row};
		if (slack_col > {2'b00, major_run}) begin
			slack_col = slack_col - {2'b00, major_run};
			pen_col   = nudge(pen_col, heading_col);
		end
		if (slack_row > {2'b00, major_run}) begin
			slack_row = slack_row - {2'b00, major_run};
			pen_row   = nudge(pen_row, heading_row);
		end
	endfunction

	// Pixel beat that one command beat gives, with the line state updated.
	function automatic lpg_pkg::pix_item_t next_pixel(input lpg_pkg::cmd_item_t beat);
		lpg_pkg::pix_item_t px;
		px = NO_PIXEL;
		if (beat.cmd == lpg_pkg::CMD_LOAD) begin
			axis_setup(beat.x_start, beat.x_end, heading_col, run_col);
			axis_setup(beat.y_start, beat.y_end, heading_row, run_row);
			major_run   = (run_col > run_row) ? run_col : run_row;
			pen_col     = beat.x_start;
			pen_row     = beat.y_start;
			slack_col   = '0;
			slack_row   = '0;
			line_hue    = beat.line_color;
			pixels_owed = {1'b0, major_run} + 1'b1;
			drawing     = 1'b1;
			px = lit_pixel(pen_col, pen_row, line_hue, 1'b0);
			bresenham_step();
		end else if (drawing) begin
			px = lit_pixel(pen_col, pen_row, line_hue, pixels_owed <= 1);
			if (pixels_owed <= 1) begin
				pixels_owed = '0;
				drawing     = 1'b0;
			end else begin
				pixels_owed = pixels_owed - 1'b1;
			end
			bresenham_step();
		end
		return px;
	endfunction

	// Gap before a beat: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_burst || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Offer one command beat from a falling edge and hold it until it is taken.
	task automatic offer(input lpg_pkg::cmd_item_t beat, input bit typed,
			input lpg_pkg::pix_item_t want);
		int                 gap;
		lpg_pkg::pix_item_t guess;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_item  <= beat;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		guess = next_pixel(beat);
		want_pixels.push_back(typed ? want : guess);
		beats_sent++;
		@(negedge clk);
	endtask

	// Stop sending until every pixel beat has come back.
	task automatic drain_pixels();
		cmd_valid <= 1'b0;
		while (want_pixels.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic coord_t pick_origin();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return coord_t'(COORD_MAX);
		return coord_t'($urandom_range(0, COORD_MAX));
	endfunction

	// End point a short distance away, kept inside the coordinate range.
	function automatic coord_t pick_partner(input coord_t from, input int reach);
		int d, base, to;
		d    = $urandom_range(0, reach);
		base = int'(from);
		to   = ($urandom_range(0, 1) == 1) ? base + d : base - d;
		if (to > COORD_MAX)
			to = base - d;
		if (to < 0)
			to = base + d;
		return coord_t'(to);
	endfunction

	// Random part: mostly whole short lines, some long lines cut off by the next load,
	// and some stray step beats.
	task automatic random_lines();
		int     r, steps, full, ddx, ddy;
		coord_t xs, ys, xe, ye;
		while (beats_sent < plan.size() + RANDOM_BEATS) begin
			r        = $urandom_range(0, 99);
			tx_burst = ($urandom_range(0, 3) == 0);
			if (r < 3) begin
				drain_pixels();
			end else if (r < 9) begin
				offer(load_cmd(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), hue_t'($urandom)), 1'b0, NO_PIXEL);
				steps = $urandom_range(1, 40);
				repeat (steps) offer(noise_step(), 1'b0, NO_PIXEL);
			end else if (r < 90) begin
				xs  = pick_origin();
				ys  = pick_origin();
				xe  = pick_partner(xs, ($urandom_range(0, 4) == 0) ? 0 : 12);
				ye  = pick_partner(ys, ($urandom_range(0, 4) == 0) ? 0 : 12);
				ddx = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
				ddy = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
				full = ((ddx > ddy) ? ddx : ddy) + 1;
				r = $urandom_range(0, 99);
				if (r < 12)
					steps = $urandom_range(0, full - 1);
				else if (r < 35)
					steps = full + $urandom_range(1, 2);
				else
					steps = full;
				offer(load_cmd(xs, ys, xe, ye, hue_t'($urandom)), 1'b0, NO_PIXEL);
				repeat (steps) offer(noise_step(), 1'b0, NO_PIXEL);
			end else begin
				repeat ($urandom_range(1, 4)) offer(noise_step(), 1'b0, NO_PIXEL);
			end
		end
	endtask

	// Pixel sink: random stall runs, calm stretches, and one long hold-off so the
	// block fills up and stalls its command side.
	initial begin : pixel_sink
		int run_left;
		int calm_left;
		bit stall_now;
		bit calm;
		bit hold_done;
		run_left  = 0;
		calm_left = 0;
		calm      = 1'b0;
		hold_done = 1'b0;
		pix_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && beats_sent >= plan.size() + 30) begin
				hold_done = 1'b1;
				pix_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (calm_left == 0) begin
					calm      = ($urandom_range(0, 3) == 0);
					calm_left = $urandom_range(20, 80);
				end
				calm_left--;
				if (run_left == 0) begin
					stall_now = !calm && ($urandom_range(0, 2) == 0);
					if (!stall_now)
						run_left = $urandom_range(1, 8);
					else if ($urandom_range(0, 99) < 85)
						run_left = $urandom_range(1, 3);
					else
						run_left = $urandom_range(4, 25);
				end
				run_left--;
				pix_stall <= stall_now;
			end
		end
	end

	// Check every pixel beat taken against the oldest expectation.
	always @(posedge clk) begin : pixel_check
		lpg_pkg::pix_item_t want;
		if (arst_n && pix_valid && !pix_stall) begin
			if (want_pixels.size() == 0) begin
				mismatches++;
				$display({"%0t: pixel mismatch: expected none, ",
					"actual x=%0d y=%0d color=%h valid=%b last=%b"},
					$time, pix_item.pixel_x, pix_item.pixel_y, pix_item.pixel_color,
					pix_item.pixel_valid, pix_item.last_pixel);
			end else begin
				want = want_pixels.pop_front();
				if (pix_item !== want) begin
					mismatches++;
					$display({"%0t: pixel mismatch: ",
						"expected x=%0d y=%0d color=%h valid=%b last=%b, ",
						"actual x=%0d y=%0d color=%h valid=%b last=%b"},
						$time, want.pixel_x, want.pixel_y, want.pixel_color,
						want.pixel_valid, want.last_pixel, pix_item.pixel_x,
						pix_item.pixel_y, pix_item.pixel_color, pix_item.pixel_valid,
						pix_item.last_pixel);
				end
			end
		end
	end

	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("line_pixel_generator_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_item  = '0;
		drawing     = 1'b0;
		pen_col     = '0;
		pen_row     = '0;
		slack_col   = '0;
		slack_row   = '0;
		run_col     = '0;
		run_row     = '0;
		heading_col = lpg_pkg::DIR_NONE;
		heading_row = lpg_pkg::DIR_NONE;
		major_run   = '0;
		pixels_owed = '0;
		line_hue    = '0;

		// Directed lines: idle step, a point, the full diagonals, a flat line, a steep one.
		plan = '{
			'{step_cmd(11'h7FF, 16'hFFFF), 1'b1, NO_PIXEL},
			'{load_cmd(11'd5, 11'd7, 11'd5, 11'd7, 16'h1234), 1'b1,
				lit_pixel(11'd5, 11'd7, 16'h1234, 1'b0)},
			'{step_cmd(11'h000, 16'h0000), 1'b1, lit_pixel(11'd5, 11'd7, 16'h1234, 1'b1)},
			'{step_cmd(11'h555, 16'h5A5A), 1'b1, NO_PIXEL},
			'{load_cmd(11'd0, 11'd0, 11'd2047, 11'd2047, 16'hFFFF), 1'b1,
				lit_pixel(11'd0, 11'd0, 16'hFFFF, 1'b0)},
			'{step_cmd(11'h2AA, 16'hA5A5), 1'b0, NO_PIXEL},
			'{step_cmd(11'h7FF, 16'h0000), 1'b0, NO_PIXEL},
			'{load_cmd(11'd2047, 11'd0, 11'd0, 11'd2047, 16'h0000), 1'b1,
				lit_pixel(11'd2047, 11'd0, 16'h0000, 1'b0)},
			'{step_cmd(11'h000, 16'hFFFF), 1'b0, NO_PIXEL},
			'{load_cmd(11'd2047, 11'd2047, 11'd0, 11'd0, 16'hAAAA), 1'b1,
				lit_pixel(11'd2047, 11'd2047, 16'hAAAA, 1'b0)},
			'{step_cmd(11'h123, 16'h4321), 1'b0, NO_PIXEL},
			'{load_cmd(11'd100, 11'd50, 11'd103, 11'd50, 16'h5555), 1'b1,
				lit_pixel(11'd100, 11'd50, 16'h5555, 1'b0)},
			'{step_cmd(11'h001, 16'h0001), 1'b0, NO_PIXEL},
			'{step_cmd(11'h002, 16'h0002), 1'b0, NO_PIXEL},
			'{step_cmd(11'h004, 16'h0004), 1'b0, NO_PIXEL},
			'{step_cmd(11'h008, 16'h0008), 1'b0, NO_PIXEL},
			'{step_cmd(11'h010, 16'h0010), 1'b1, NO_PIXEL},
			'{load_cmd(11'd10, 11'd20, 11'd8, 11'd25, 16'h07E0), 1'b1,
				lit_pixel(11'd10, 11'd20, 16'h07E0, 1'b0)},
			'{step_cmd(11'h020, 16'h0020), 1'b0, NO_PIXEL},
			'{step_cmd(11'h040, 16'h0040), 1'b0, NO_PIXEL},
			'{step_cmd(11'h080, 16'h0080), 1'b0, NO_PIXEL},
			'{step_cmd(11'h100, 16'h0100), 1'b0, NO_PIXEL},
			'{step_cmd(11'h200, 16'h0200), 1'b0, NO_PIXEL},
			'{step_cmd(11'h400, 16'h0400), 1'b0, NO_PIXEL},
			'{step_cmd(11'h7FF, 16'h8000), 1'b1, NO_PIXEL}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			offer(plan[i].beat, plan[i].typed, plan[i].want);

		// Let every directed pixel come back before the random part starts.
		drain_pixels();
		random_lines();

		// Wait for the last pixel beats, then give any stray beat time to show.
		cmd_valid <= 1'b0;
		while (want_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && want_pixels.size() == 0)
			$display("line_pixel_generator_core regression: pass");
		else
			$display("line_pixel_generator_core regression: fail");
		$finish;
	end

endmodule

[files.f]
design/lpg_pkg.sv
design/lpg_front.sv
design/lpg_queue.sv
design/lpg_back.sv
design/line_pixel_generator_core.sv
dv/line_pixel_generator_core_tb.sv
